// ===== rtl/core/swnm_pkg.sv =====
// Shared constants for the star wildcard name matcher.
package swnm_pkg;

   // Character handling
   localparam int CHAR_W = 8;
   localparam logic [CHAR_W-1:0] CHAR_FLIP = 8'h80;
   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
   localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;

   // Pattern storage layout
   localparam int CHAR_SLOTS = 32;
   localparam int PATTERN_REGS = 4;
   localparam int CHARS_PER_REG = 8;
   localparam int PAT_SEL_W = 2;
   localparam int LEN_W = 6;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_A = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_B = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_C = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_D = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_LEN = 3'd4;

endpackage

// ===== rtl/core/swnm_closure.sv =====
// Parallel-prefix star closure over the pattern position set.
module swnm_closure #(
   parameter int W = 33
) (
   input  logic [W-1:0] set_in,
   input  logic [W-1:0] prop_in,
   output logic [W-1:0] set_out
);

   localparam int LEVELS = $clog2(W);

   // A set position spreads forward through every run of stars that follows it.
   // prop_in[j] means position j is reachable from position j-1.
   always_comb begin
      logic [W-1:0] g;
      logic [W-1:0] p;
      g = set_in;
      p = prop_in;
      for (int k = 0; k < LEVELS; k++) begin
         g = g | (p & (g << (1 << k)));
         p = p & (p << (1 << k));
      end
      set_out = g;
   end

endmodule

// ===== rtl/core/star_wildcard_name_matcher.sv =====
// Top level of the star wildcard name matcher: pattern registers, NFA state and handshakes.
//
//   Port group   Direction   Handshake            Contents
//   req_*        in          req_valid/req_stall  name_byte, last_byte
//   rsp_*        out         rsp_valid/rsp_stall  matched (one per name, at its last byte)
//   csr_*        in          csr_write            pattern_chars_a..d, pattern_length
//
// One request is taken every cycle while req_stall is low; a name byte waits in the input
// register, and the result of its last byte is then registered in the result register.
// The cycle time is set by one bit-parallel NFA update: a character compare per pattern
// position followed by a log-depth prefix network for the star closure.
// Reset is synchronous: it clears the pattern, the length and both valid flags.
// A held response stalls the input register only when it carries another last byte.
module star_wildcard_name_matcher #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [swnm_pkg::CHAR_W-1:0]      req_name_byte,
   input  logic                             req_last_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_matched,
   input  logic                             csr_write,
   input  logic [swnm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [swnm_pkg::CSR_DATA_W-1:0]  csr_data
);

   import swnm_pkg::*;

   localparam int EFF_MAX = (MAX_PATTERN < CHAR_SLOTS) ? MAX_PATTERN : CHAR_SLOTS;
   localparam int NPOS = EFF_MAX + 1;
   localparam int LW = $clog2(NPOS);

   logic [CSR_DATA_W-1:0] pat_ff [PATTERN_REGS];
   logic [LEN_W-1:0]      len_ff;
   logic                  s1_valid_ff;
   logic [CHAR_W-1:0]     s1_char_ff;
   logic                  s1_last_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_matched_ff;
   logic [NPOS-1:0]       active_ff;
   logic [NPOS-1:0]       before_ff;
   logic                  fresh_ff;
   logic                  fresh_in;

   logic [LW-1:0]         eff_len;
   logic [CHAR_W-1:0]     pat_char [EFF_MAX];
   logic [EFF_MAX-1:0]    star_mask;
   logic [EFF_MAX-1:0]    hit_mask;
   logic [NPOS-1:0]       start_set;
   logic [NPOS-1:0]       cur_set;
   logic [NPOS-1:0]       cur_before;
   logic [NPOS-1:0]       step_set;
   logic [NPOS-1:0]       next_set;
   logic [NPOS-1:0]       next_before;
   logic                  matched;
   logic                  cfg_hit;
   logic                  out_free;
   logic                  s1_fire;
   logic                  req_take;

   // Effective pattern length saturates at the number of positions kept.
   assign eff_len = (len_ff > LEN_W'(EFF_MAX)) ? LW'(EFF_MAX) : LW'(len_ff);

   // Per-position character compare against the byte in the input register.
   for (genvar i = 0; i < EFF_MAX; i++) begin : g_pos
      logic in_len;
      assign pat_char[i] = pat_ff[i / CHARS_PER_REG][(i % CHARS_PER_REG) * CHAR_W +: CHAR_W];
      assign in_len = LW'(i) < eff_len;
      assign star_mask[i] = in_len && (pat_char[i] == STAR_CHAR);
      assign hit_mask[i] = in_len && (pat_char[i] != STAR_CHAR) && (pat_char[i] == s1_char_ff);
   end

   // Start set: position zero plus the leading stars.
   swnm_closure #(.W(NPOS)) u_start_closure (
      .set_in  (NPOS'(1)),
      .prop_in ({star_mask, 1'b0}),
      .set_out (start_set)
   );

   // A fresh name begins from the start set of the current pattern.
   assign cur_set = fresh_ff ? start_set : active_ff;
   assign cur_before = fresh_ff ? start_set : before_ff;

   // Stars keep their position, matching characters advance by one.
   assign step_set = {1'b0, cur_set[EFF_MAX-1:0] & star_mask}
                   | {cur_set[EFF_MAX-1:0] & hit_mask, 1'b0};

   swnm_closure #(.W(NPOS)) u_step_closure (
      .set_in  (step_set),
      .prop_in ({star_mask, 1'b0}),
      .set_out (next_set)
   );

   // Trailing spaces do not move the set that the verdict is taken from.
   assign next_before = (s1_char_ff != SPACE_CHAR) ? next_set : cur_before;
   assign matched = next_before[eff_len];

   // Handshake control.
   assign cfg_hit = csr_write && (csr_index <= CSR_PAT_LEN);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_fire = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_take = req_valid && !req_stall;

   // The state restarts after a result and after any write to a pattern or length register.
   always_comb begin
      fresh_in = fresh_ff;
      if (s1_fire) begin
         fresh_in = s1_last_ff;
      end
      if (cfg_hit) begin
         fresh_in = 1'b1;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PATTERN_REGS; k++) begin
            pat_ff[k] <= '0;
         end
         len_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PAT_A, CSR_PAT_B, CSR_PAT_C, CSR_PAT_D: begin
               pat_ff[csr_index[PAT_SEL_W-1:0]] <= csr_data;
            end
            CSR_PAT_LEN: begin
               len_ff <= csr_data[LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Input register, NFA state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fresh_ff <= 1'b1;
      end else begin
         fresh_ff <= fresh_in;
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_name_byte ^ CHAR_FLIP;
         s1_last_ff <= req_last_byte;
      end
      if (s1_fire) begin
         active_ff <= next_set;
         before_ff <= next_before;
      end
      if (s1_fire && s1_last_ff) begin
         rsp_matched_ff <= matched;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

   // A last byte that leaves the input register always lands in the result register.
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=> rsp_valid_ff)
      else $error("last byte did not produce a result");

   // A write to a pattern or length register restarts the name state.
   a_cfg_restarts: assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> fresh_ff)
      else $error("register write did not restart the state");

   // A middle byte leaves the state in progress.
   a_mid_byte_keeps_name: assert property (@(posedge clock) disable iff (reset)
      s1_fire && !s1_last_ff && !cfg_hit |=> !fresh_ff)
      else $error("middle byte restarted the state");

   // Without a step or a write the state holds.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !s1_fire && !cfg_hit |=> $stable(fresh_ff) && (fresh_ff || $stable(active_ff)))
      else $error("state changed without a step");

   // Requests are held back only behind a last byte blocked by a held response.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a blocked result");

endmodule

// ===== tb/star_wildcard_name_matcher_tb.sv =====
// Self-checking testbench for the star wildcard name matcher.
module star_wildcard_name_matcher_tb;
   import swnm_pkg::*;

   localparam int MAX_PATTERN = 32;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD = 300;
   localparam int QUIET_LIMIT = 3000;
   localparam int PHASES = 8;
   localparam int PHASE_BYTES = 75;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_SPARE = CSR_PAT_LEN + 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_SPARE = '1;

   typedef struct packed {
      logic [CHAR_W-1:0] name_byte;
      logic              last_byte;
   } name_req_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [CHAR_W-1:0]      req_name_byte = '0;
   logic                   req_last_byte = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_matched;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Pattern registers and match state as the block should hold them.
   logic [CSR_DATA_W-1:0] pattern_word [PATTERN_REGS];
   logic [LEN_W-1:0]      pattern_len;
   logic [CHAR_SLOTS:0]   live_set;
   logic [CHAR_SLOTS:0]   trimmed_set;
   logic [CHAR_W-1:0]     pattern_plan [CHAR_SLOTS];

   name_req_type pending_bytes[$];
   logic         verdict_queue[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatch_count = 0;
   int unsigned names_checked = 0;
   int unsigned names_matched = 0;
   int unsigned bytes_queued = 0;
   int unsigned settings_count = 0;

   star_wildcard_name_matcher #(
      .MAX_PATTERN(MAX_PATTERN)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_name_byte(req_name_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_matched  (rsp_matched),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Number of pattern positions in use, with oversized lengths saturated.
   function automatic int unsigned used_length();
      int unsigned cap;
      cap = (MAX_PATTERN < CHAR_SLOTS) ? MAX_PATTERN : CHAR_SLOTS;
      return (pattern_len > cap) ? cap : pattern_len;
   endfunction

   function automatic logic [CHAR_W-1:0] pattern_char(int unsigned pos);
      return pattern_word[pos / CHARS_PER_REG][(pos % CHARS_PER_REG) * CHAR_W +: CHAR_W];
   endfunction

   // A star at an active position also makes the following position active.
   function automatic logic [CHAR_SLOTS:0] close_over_stars(logic [CHAR_SLOTS:0] set);
      int unsigned i;
      for (i = 0; i < used_length(); i++) begin
         if (set[i] && pattern_char(i) == STAR_CHAR) set[i+1] = 1'b1;
      end
      return set;
   endfunction

   // One character step of the position set: stars stay, literals move on a hit.
   function automatic logic [CHAR_SLOTS:0] advance_positions(logic [CHAR_SLOTS:0] set,
                                                             logic [CHAR_W-1:0] ch);
      logic [CHAR_SLOTS:0] next_set;
      int unsigned i;
      next_set = '0;
      for (i = 0; i < used_length(); i++) begin
         if (set[i]) begin
            if (pattern_char(i) == STAR_CHAR) next_set[i] = 1'b1;
            else if (pattern_char(i) == ch) next_set[i+1] = 1'b1;
         end
      end
      return close_over_stars(next_set);
   endfunction

   task automatic restart_match();
      live_set = close_over_stars({{CHAR_SLOTS{1'b0}}, 1'b1});
      trimmed_set = live_set;
   endtask

   // Updates the match state for one accepted request and records any verdict.
   task automatic account_byte(input logic [CHAR_W-1:0] raw, input logic last);
      logic [CHAR_W-1:0] ch;
      logic verdict;
      ch = raw ^ CHAR_FLIP;
      live_set = advance_positions(live_set, ch);
      if (ch != SPACE_CHAR) trimmed_set = live_set;
      if (last) begin
         verdict = trimmed_set[used_length()];
         verdict_queue.push_back(verdict);
         names_checked++;
         if (verdict) names_matched++;
         restart_match();
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Request driver: holds a request until it is taken, then offers the next or idles.
   always @(posedge clock) begin : drive_requests
      logic taken;
      name_req_type next_req;
      taken = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (taken) account_byte(req_name_byte, req_last_byte);
         if (!req_valid || taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_req = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_name_byte <= next_req.name_byte;
               req_last_byte <= next_req.last_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each verdict in order and drives the stall.
   always @(posedge clock) begin : check_responses
      logic want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_queue.size() == 0) begin
               report_mismatch("result arrived with no name pending");
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_matched !== want)
                  report_mismatch($sformatf("matched is %b, expected %b", rsp_matched, want));
            end
         end
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // Watchdog: ends the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout after %0d cycles without progress", quiet_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic queue_byte(input logic [CHAR_W-1:0] raw, input logic last);
      name_req_type item;
      item.name_byte = raw;
      item.last_byte = last;
      pending_bytes.push_back(item);
      bytes_queued++;
   endtask

   task automatic queue_text(input string s, input logic ends_name);
      int i;
      for (i = 0; i < s.len(); i++)
         queue_byte(s[i] ^ CHAR_FLIP, ends_name && i == s.len() - 1);
   endtask

   function automatic logic [CHAR_W-1:0] random_char();
      case ($urandom_range(0, 4))
         0: return "A";
         1: return "B";
         2: return STAR_CHAR;
         3: return SPACE_CHAR;
         default: return CHAR_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Writes one register; the match state restarts on any listed register.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      if (index < PATTERN_REGS) pattern_word[index[PAT_SEL_W-1:0]] = data;
      else if (index == CSR_PAT_LEN) pattern_len = data[LEN_W-1:0];
      if (index <= CSR_PAT_LEN) restart_match();
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Packs the planned characters into the four words and sets the length.
   task automatic program_pattern(input logic [LEN_W-1:0] length_value);
      logic [CSR_DATA_W-1:0] word;
      int unsigned r, k;
      for (r = 0; r < PATTERN_REGS; r++) begin
         for (k = 0; k < CHARS_PER_REG; k++)
            word[k*CHAR_W +: CHAR_W] = pattern_plan[r*CHARS_PER_REG + k];
         write_register(CSR_INDEX_W'(r), word);
      end
      word = {$urandom, $urandom};
      word[LEN_W-1:0] = length_value;
      write_register(CSR_PAT_LEN, word);
      if ($urandom_range(0, 2) == 0)
         write_register(CSR_INDEX_W'($urandom_range(CSR_FIRST_SPARE, CSR_LAST_SPARE)),
                        {$urandom, $urandom});
      settings_count++;
   endtask

   // Picks the pattern of one random phase; slots beyond the length hold junk.
   task automatic choose_pattern(input int unsigned phase);
      int unsigned i, len;
      for (i = 0; i < CHAR_SLOTS; i++) begin
         case ($urandom_range(0, 5))
            0: pattern_plan[i] = "A";
            1: pattern_plan[i] = "B";
            2: pattern_plan[i] = "C";
            3: pattern_plan[i] = SPACE_CHAR;
            default: pattern_plan[i] = STAR_CHAR;
         endcase
      end
      case (phase)
         0: len = $urandom_range(1, 8);
         1: len = CHAR_SLOTS;
         2: begin
            // All-zero registers; only all-space names can match.
            foreach (pattern_plan[i]) pattern_plan[i] = '0;
            len = 0;
         end
         3: len = $urandom_range(2, 6);
         4: begin
            foreach (pattern_plan[i]) pattern_plan[i] = STAR_CHAR;
            len = $urandom_range(1, 12);
         end
         5: len = (1 << LEN_W) - 1;
         6: begin
            foreach (pattern_plan[i]) pattern_plan[i] = '1;
            len = 5;
         end
         default: len = $urandom_range(1, 12);
      endcase
      program_pattern(LEN_W'(len));
   endtask

   // Mostly names built to follow the pattern, with some noise and all-space names.
   task automatic queue_name();
      logic [CHAR_W-1:0] chars[$];
      logic [CHAR_W-1:0] c;
      int unsigned i, extra;
      logic all_space;
      if ($urandom_range(0, 4) == 0) begin
         extra = $urandom_range(1, 6);
         all_space = ($urandom_range(0, 4) == 0);
         repeat (extra) chars.push_back(all_space ? SPACE_CHAR : random_char());
      end else begin
         for (i = 0; i < used_length(); i++) begin
            c = pattern_char(i);
            if (c == STAR_CHAR) begin
               repeat ($urandom_range(0, 3)) chars.push_back(random_char());
            end else begin
               chars.push_back(($urandom_range(0, 19) == 0) ? random_char() : c);
            end
         end
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) chars.push_back(SPACE_CHAR);
      end
      if (chars.size() == 0) chars.push_back(SPACE_CHAR);
      foreach (chars[k]) queue_byte(chars[k] ^ CHAR_FLIP, k == chars.size() - 1);
   endtask

   // Waits until every request is taken and every verdict has come back.
   task automatic settle();
      while (pending_bytes.size() != 0 || req_valid || verdict_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : run_regression
      int unsigned phase, phase_start, i;
      string text;
      for (i = 0; i < PATTERN_REGS; i++) pattern_word[i] = '0;
      pattern_len = '0;
      restart_match();
      send_idle_pct = 31;
      recv_idle_pct = 68;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Out of reset the length is zero: a lone space matches, any other byte does not.
      queue_text(" ", 1'b1);
      queue_byte(8'h00, 1'b1);
      settle();

      // H*LO needs a star that can give back characters.
      text = "H*LO";
      for (i = 0; i < CHAR_SLOTS; i++)
         pattern_plan[i] = (i < text.len()) ? text[i] : CHAR_W'($urandom_range(0, 255));
      program_pattern(LEN_W'(text.len()));
      queue_text("HELLO", 1'b1);
      queue_text("HLO  ", 1'b1);
      queue_text("H*LO", 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_text("HE", 1'b0);
      settle();
      // A write to an unused index must not disturb the name in progress.
      write_register(CSR_FIRST_SPARE, '1);
      queue_text("LLO", 1'b1);
      settle();

      // Random phases, each under a new pattern; a trailing partial name may get abandoned.
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 3) begin
            send_idle_pct = 68;
            recv_idle_pct = 31;
         end else if (phase == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         choose_pattern(phase);
         if (phase == 3) hold_requests++;
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < PHASE_BYTES) queue_name();
         if ($urandom_range(0, 1) == 0)
            repeat ($urandom_range(1, 3)) queue_byte(random_char() ^ CHAR_FLIP, 1'b0);
         settle();
      end

      if (verdict_queue.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", verdict_queue.size()));
      $display("Checked %0d names (%0d matching) from %0d name bytes under %0d patterns,",
               names_checked, names_matched, bytes_queued, settings_count);
      $display("with stalls on both sides, one long response hold and a full-rate stretch.");
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/swnm_pkg.sv
rtl/core/swnm_closure.sv
rtl/core/star_wildcard_name_matcher.sv
tb/star_wildcard_name_matcher_tb.sv
